// ===== rtl/swkr_pkg.sv =====
// swkr_pkg: types and codes shared by the keyed-removal stack.
// Used by swkr_cell and stack_with_keyed_removal_unit; no dependencies.
package swkr_pkg;

  // counter/index width large enough for any supported depth (up to 63)
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_REMOVED = 2'd1,
    KIND_LISTED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOINIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_LIST,
    S_DONE
  } state_t;

  // per-cycle move of the cell chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,   // every cell takes its upper neighbor, cell 0 takes the new entry
    OP_POP     // every cell takes its lower neighbor, head may re-enter at app_idx
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             app_en;
    logic [CNT_W-1:0] app_idx;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [31:0] plate;
    logic        [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] plate;
    logic        [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [1:0]  status;
    logic signed [31:0] entry_plate;
    logic        [31:0] entry_payload;
    logic               last;
  } out_item_t;

endpackage

// ===== rtl/swkr_cell.sv =====
// swkr_cell: one stack slot of the chain; holds one entry.
// Depends on swkr_pkg for the entry and chain control types.
module swkr_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  swkr_pkg::cell_ctl_t ctl,
  input  swkr_pkg::entry_t    above,   // neighbor nearer the top (or new entry)
  input  swkr_pkg::entry_t    below,   // neighbor farther from the top
  input  swkr_pkg::entry_t    head,    // entry leaving cell 0 this cycle
  output swkr_pkg::entry_t    q
);

  swkr_pkg::entry_t q_next;
  logic             app_hit;

  assign app_hit = ctl.app_en && (ctl.app_idx == swkr_pkg::CNT_W'(IDX));

  // select next content
  always_comb begin
    case (ctl.op)
      swkr_pkg::OP_PUSH: q_next = above;
      swkr_pkg::OP_POP:  q_next = app_hit ? head : below;
      default:           q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== rtl/stack_with_keyed_removal_unit.sv =====
// Keyed-removal stack: clear and push accept the command, then emit a done item; list emits
// fill+1 items (fill entries, then done); remove-by-plate runs a match walk, a listing walk
// over survivors, then done. List and remove on an empty or uninitialized stack go to done.
// One command at a time; a walk step advances only when the result register is free, so
// output stall stretches the walk. Reset (synchronous, active high) empties the stack and
// marks it uninitialized; entry contents are not reset.
module stack_with_keyed_removal_unit #(
  parameter int DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  swkr_pkg::in_item_t    cmd_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output swkr_pkg::out_item_t   res_data
);

  localparam int CW = $clog2(DEPTH + 1);

  swkr_pkg::state_t    state, state_next;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       t;
  logic [CW-1:0]       kept;
  logic [CW-1:0]       kept_next;
  logic [CW-1:0]       app_idx;
  logic                started;
  logic signed [31:0]  key;
  swkr_pkg::status_t   status;

  logic                slot;
  logic                accept;
  logic                last_step;
  logic                match;
  logic                emit;
  swkr_pkg::out_item_t emit_item;
  swkr_pkg::cell_ctl_t ctl;
  swkr_pkg::entry_t    new_entry;
  swkr_pkg::entry_t    cells [DEPTH];

  assign slot      = !res_valid || !res_stall;
  assign cmd_stall = (state != swkr_pkg::S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign last_step = (t == fill - CW'(1));
  assign match     = (cells[0].plate == key);
  assign kept_next = kept + CW'(!match);
  // unprocessed entries sit above the kept ones; head re-enters right after them
  assign app_idx   = fill - t - CW'(1) + kept;

  assign new_entry.plate   = cmd_data.plate;
  assign new_entry.payload = cmd_data.payload;

  // cell chain, cell 0 is the top of stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    swkr_pkg::entry_t above, below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign below = cells[i];
    end else begin : g_inner
      assign below = cells[i+1];
    end
    swkr_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .head  (cells[0]),
      .q     (cells[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      swkr_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_data.cmd == swkr_pkg::CMD_CLEAR || cmd_data.cmd == swkr_pkg::CMD_PUSH ||
              !started || fill == '0) begin
            state_next = swkr_pkg::S_DONE;
          end else if (cmd_data.cmd == swkr_pkg::CMD_REMOVE) begin
            state_next = swkr_pkg::S_REMOVE;
          end else begin
            state_next = swkr_pkg::S_LIST;
          end
        end
      end
      swkr_pkg::S_REMOVE: begin
        if (slot && last_step) begin
          state_next = (kept_next == '0) ? swkr_pkg::S_DONE : swkr_pkg::S_LIST;
        end
      end
      swkr_pkg::S_LIST: begin
        if (slot && last_step) state_next = swkr_pkg::S_DONE;
      end
      swkr_pkg::S_DONE: begin
        if (slot) state_next = swkr_pkg::S_IDLE;
      end
      default: state_next = swkr_pkg::S_IDLE;
    endcase
  end

  // chain control and result selection
  always_comb begin
    ctl.op                  = swkr_pkg::OP_HOLD;
    ctl.app_en              = 1'b0;
    ctl.app_idx             = swkr_pkg::CNT_W'(app_idx);
    emit                    = 1'b0;
    emit_item.kind          = swkr_pkg::KIND_DONE;
    emit_item.status        = swkr_pkg::ST_OK;
    emit_item.entry_plate   = cells[0].plate;
    emit_item.entry_payload = cells[0].payload;
    emit_item.last          = 1'b0;
    case (state)
      swkr_pkg::S_IDLE: begin
        if (accept && cmd_data.cmd == swkr_pkg::CMD_PUSH && started &&
            fill != CW'(DEPTH)) begin
          ctl.op = swkr_pkg::OP_PUSH;
        end
      end
      swkr_pkg::S_REMOVE: begin
        if (slot) begin
          ctl.op         = swkr_pkg::OP_POP;
          ctl.app_en     = !match;
          emit           = match;
          emit_item.kind = swkr_pkg::KIND_REMOVED;
        end
      end
      swkr_pkg::S_LIST: begin
        if (slot) begin
          ctl.op         = swkr_pkg::OP_POP;
          ctl.app_en     = 1'b1;
          emit           = 1'b1;
          emit_item.kind = swkr_pkg::KIND_LISTED;
        end
      end
      swkr_pkg::S_DONE: begin
        emit                    = slot;
        emit_item.status        = status;
        emit_item.entry_plate   = '0;
        emit_item.entry_payload = '0;
        emit_item.last          = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swkr_pkg::S_IDLE;
      fill      <= '0;
      started   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (slot) res_valid <= emit;
      case (state)
        swkr_pkg::S_IDLE: begin
          if (accept) begin
            if (cmd_data.cmd == swkr_pkg::CMD_CLEAR) begin
              started <= 1'b1;
              fill    <= '0;
            end else if (started && cmd_data.cmd == swkr_pkg::CMD_PUSH &&
                         fill != CW'(DEPTH)) begin
              fill <= fill + CW'(1);
            end
          end
        end
        swkr_pkg::S_REMOVE: begin
          if (slot && last_step) fill <= kept_next;
        end
        default: ;
      endcase
    end
  end

  // walk counters, key, status and result payload
  always_ff @(posedge clk) begin
    if (slot && emit) res_data <= emit_item;
    case (state)
      swkr_pkg::S_IDLE: begin
        t    <= '0;
        kept <= '0;
        if (accept) begin
          key <= cmd_data.plate;
          if (cmd_data.cmd == swkr_pkg::CMD_CLEAR) begin
            status <= swkr_pkg::ST_OK;
          end else if (!started) begin
            status <= swkr_pkg::ST_NOINIT;
          end else if (cmd_data.cmd == swkr_pkg::CMD_PUSH) begin
            status <= (fill == CW'(DEPTH)) ? swkr_pkg::ST_FULL : swkr_pkg::ST_OK;
          end else begin
            status <= (fill == '0) ? swkr_pkg::ST_EMPTY : swkr_pkg::ST_OK;
          end
        end
      end
      swkr_pkg::S_REMOVE: begin
        if (slot) begin
          t    <= last_step ? '0 : t + CW'(1);
          kept <= last_step ? '0 : kept_next;
        end
      end
      swkr_pkg::S_LIST: begin
        if (slot) begin
          t    <= last_step ? '0 : t + CW'(1);
          kept <= last_step ? '0 : kept + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("stack fill count above depth");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == swkr_pkg::S_REMOVE || state == swkr_pkg::S_LIST) |-> fill != '0)
    else $error("walk running over an empty stack");

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.last |-> res_data.kind == swkr_pkg::KIND_DONE)
    else $error("final transfer of a command is not a done item");

  a_noinit_no_entries: assert property (@(posedge clk) disable iff (rst)
    res_valid && !started |-> res_data.kind == swkr_pkg::KIND_DONE)
    else $error("entry reported before the stack was initialized");

endmodule
